[src/tks_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types, constants and arithmetic helpers for the knob smoother and
// selector.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned RAW_W      = 12;
  localparam int unsigned VAL_W      = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CHG_R_W    = 16;
  localparam int unsigned PROD_W     = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WINDOW_DEF = 10;
  localparam int unsigned PCT_FULL   = 100;

  localparam logic [11:0] MIN_CHANGE_RST   = 12'd3;
  localparam logic [3:0]  SWITCH_RATIO_RST = 4'd3;
  localparam logic [15:0] REFRESH_RST      = 16'd50;
  localparam logic [9:0]  MS_STEP_RST      = 10'd5;
  localparam logic [6:0]  PCT_STEP_RST     = 7'd2;
  localparam logic [9:0]  FULL_SCALE_RST   = 10'd500;

  typedef enum logic [1:0] {
    CH_DELAY    = 2'd0,
    CH_FEEDBACK = 2'd1,
    CH_LEVEL    = 2'd2,
    CH_NONE     = 2'd3
  } chan_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_CHANGE   = 3'd0,
    REG_SWITCH_RATIO = 3'd1,
    REG_REFRESH      = 3'd2,
    REG_MS_STEP      = 3'd3,
    REG_PCT_STEP     = 3'd4,
    REG_FULL_SCALE   = 3'd5
  } reg_idx_e;

  typedef logic [RAW_W-1:0] raw_t;
  typedef raw_t [NUM_CH-1:0] raw_vec_t;

  typedef struct packed {
    logic [11:0] min_change;
    logic [3:0]  switch_ratio;
    logic [15:0] refresh_ms;
    logic [9:0]  ms_step;
    logic [6:0]  pct_step;
    logic [9:0]  full_scale;
  } cfg_t;

  typedef struct packed {
    logic              first;
    raw_vec_t          cur;
    logic [TIME_W-1:0] now;
  } avg_item_t;

  typedef struct packed {
    logic                            first;
    raw_vec_t                        cur;
    logic [NUM_CH-1:0][CHG_R_W-1:0]  chg_scaled;
    raw_t                            max_chg;
    chan_e                           mover;
    logic                            mover_vld;
    logic [NUM_CH-1:0][PROD_W-1:0]   prod;
    logic [TIME_W-1:0]               now;
  } trk_item_t;

  // filtered reading times full scale (ms) or 100 (percent)
  function automatic logic [PROD_W-1:0] scale_prod(chan_e ch, raw_t f, logic [9:0] full_scale);
    logic [PROD_W-1:0] mult;
    mult = (ch == CH_DELAY) ? PROD_W'(full_scale) : PROD_W'(PCT_FULL);
    return PROD_W'(f) * mult;
  endfunction

  // exact floor(x / 4095) while the quotient fits in VAL_W bits (x below 1024 * 4095)
  function automatic logic [VAL_W-1:0] div_4095(logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + (PROD_W+1)'(x >> RAW_W) + (PROD_W+1)'(1);
    return t[RAW_W +: VAL_W];
  endfunction

  function automatic raw_t abs_diff(raw_t a, raw_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[src/three_knob_smoother_selector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_knob_smoother_selector
// Moving-average smoothing of three knob readings with selection of the knob
// being turned and generation of display update transactions.
// ----------------------------------------------------------------------------
// Takes one input transaction per clock unless backpressure holds it, and
// returns its display transaction, if any; the rate is set by the window
// memory, whose single write and registered read-ahead per cycle keep the
// running sums current, and by the selection stage that updates its state
// once per cycle. The window memory needs no clearing pass after reset: slots not yet
// rewritten read as the first reading. Backpressure on the result holds the
// pipeline only once all stages are occupied.
module three_knob_smoother_selector #(
  parameter int unsigned WINDOW = tks_pkg::WINDOW_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tks_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tks_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tks_pkg::RAW_W-1:0]         raw_delay_i,
  input  logic [tks_pkg::RAW_W-1:0]         raw_feedback_i,
  input  logic [tks_pkg::RAW_W-1:0]         raw_level_i,
  input  logic [tks_pkg::TIME_W-1:0]        now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        shown_channel_o,
  output logic [tks_pkg::VAL_W-1:0]         shown_value_o
);
  import tks_pkg::*;

  localparam int unsigned SUM_W = RAW_W + $clog2(WINDOW);

  cfg_t cfg_q;
  raw_vec_t raw_vec;
  logic win_vld, win_rdy, win_first;
  logic [NUM_CH-1:0][SUM_W-1:0] win_sum;
  logic [TIME_W-1:0] win_now;
  logic avg_vld, avg_rdy;
  avg_item_t avg_item;
  logic trk_vld, trk_rdy;
  trk_item_t trk_item;
  chan_e shown_ch;

  assign raw_vec = {raw_level_i, raw_feedback_i, raw_delay_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_change   <= MIN_CHANGE_RST;
      cfg_q.switch_ratio <= SWITCH_RATIO_RST;
      cfg_q.refresh_ms   <= REFRESH_RST;
      cfg_q.ms_step      <= MS_STEP_RST;
      cfg_q.pct_step     <= PCT_STEP_RST;
      cfg_q.full_scale   <= FULL_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_CHANGE:   cfg_q.min_change   <= cfg_wdata_i[11:0];
        REG_SWITCH_RATIO: cfg_q.switch_ratio <= cfg_wdata_i[3:0];
        REG_REFRESH:      cfg_q.refresh_ms   <= cfg_wdata_i[15:0];
        REG_MS_STEP:      cfg_q.ms_step      <= cfg_wdata_i[9:0];
        REG_PCT_STEP:     cfg_q.pct_step     <= cfg_wdata_i[6:0];
        REG_FULL_SCALE:   cfg_q.full_scale   <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  tks_window #(.WINDOW(WINDOW)) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .raw_i       (raw_vec),
    .now_i       (now_ms_i),
    .out_valid_o (win_vld),
    .out_ready_i (win_rdy),
    .first_o     (win_first),
    .sum_o       (win_sum),
    .now_o       (win_now)
  );

  tks_average #(.WINDOW(WINDOW)) u_average (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (win_vld),
    .in_ready_o  (win_rdy),
    .first_i     (win_first),
    .sum_i       (win_sum),
    .now_i       (win_now),
    .out_valid_o (avg_vld),
    .out_ready_i (avg_rdy),
    .item_o      (avg_item)
  );

  tks_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (avg_vld),
    .in_ready_o  (avg_rdy),
    .item_i      (avg_item),
    .out_valid_o (trk_vld),
    .out_ready_i (trk_rdy),
    .item_o      (trk_item)
  );

  tks_display u_display (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (trk_vld),
    .in_ready_o  (trk_rdy),
    .item_i      (trk_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .channel_o   (shown_ch),
    .value_o     (shown_value_o)
  );

  assign shown_channel_o = shown_ch;

  a_no_none_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (shown_channel_o != CH_NONE))
    else $error("result carries no channel");

  a_percent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (shown_channel_o != CH_DELAY)) |-> (shown_value_o <= VAL_W'(PCT_FULL)))
    else $error("percent value out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while result side is free");

endmodule

[src/tks_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_window
// Sample window memory and running sums; the oldest sample is read ahead
// and replaced by the new reading of every transaction after the first.
// ----------------------------------------------------------------------------
module tks_window #(
  parameter int unsigned WINDOW = tks_pkg::WINDOW_DEF,
  localparam int unsigned SUM_W = tks_pkg::RAW_W + $clog2(WINDOW)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  tks_pkg::raw_vec_t                       raw_i,
  input  logic [tks_pkg::TIME_W-1:0]              now_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    first_o,
  output logic [tks_pkg::NUM_CH-1:0][SUM_W-1:0]   sum_o,
  output logic [tks_pkg::TIME_W-1:0]              now_o
);
  import tks_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned MEM_W  = NUM_CH * RAW_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [MEM_W-1:0] mem [WINDOW];
  logic [MEM_W-1:0] rd_q;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic primed_q, wrapped_q, wrapped_d, vld_q, first_q;
  logic in_fire, wr_en;
  raw_vec_t seed_q, old_raw;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_q, sum_d;
  logic [TIME_W-1:0] now_q;

  assign in_ready_o = !vld_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign wr_en      = in_fire && primed_q;

  always_comb begin
    slot_d    = slot_q;
    wrapped_d = wrapped_q;
    if (wr_en) begin
      slot_d    = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
      wrapped_d = wrapped_q || (slot_q == LAST_SLOT);
    end
  end

  // slots not yet rewritten since the first transaction read as its reading
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      old_raw[c] = wrapped_q ? rd_q[c*RAW_W +: RAW_W] : seed_q[c];
      if (primed_q) begin
        sum_d[c] = sum_q[c] - SUM_W'(old_raw[c]) + SUM_W'(raw_i[c]);
      end else begin
        sum_d[c] = SUM_W'(raw_i[c]) * SUM_W'(WINDOW);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[slot_q] <= raw_i;
    end
    rd_q <= mem[slot_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q  <= 1'b0;
      wrapped_q <= 1'b0;
      slot_q    <= '0;
      vld_q     <= 1'b0;
    end else begin
      slot_q    <= slot_d;
      wrapped_q <= wrapped_d;
      if (in_fire) begin
        primed_q <= 1'b1;
      end
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sum_q   <= sum_d;
      now_q   <= now_i;
      first_q <= !primed_q;
      if (!primed_q) begin
        seed_q <= raw_i;
      end
    end
  end

  assign out_valid_o = vld_q;
  assign first_o     = first_q;
  assign sum_o       = sum_q;
  assign now_o       = now_q;

endmodule

[src/tks_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_average
// Two-stage truncating divide of the running sums by the window length:
// reciprocal multiply, then a single remainder correction.
// ----------------------------------------------------------------------------
module tks_average #(
  parameter int unsigned WINDOW = tks_pkg::WINDOW_DEF,
  localparam int unsigned SUM_W = tks_pkg::RAW_W + $clog2(WINDOW)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    first_i,
  input  logic [tks_pkg::NUM_CH-1:0][SUM_W-1:0]   sum_i,
  input  logic [tks_pkg::TIME_W-1:0]              now_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output tks_pkg::avg_item_t                      item_o
);
  import tks_pkg::*;

  localparam int unsigned RECIP = (2 ** SUM_W) / WINDOW;

  logic a_vld_q, b_vld_q, a_ready, b_ready;
  logic a_first_q;
  logic [NUM_CH-1:0][SUM_W-1:0] a_sum_q;
  raw_vec_t a_est_q, est_d, cur_d;
  logic [NUM_CH-1:0][2*SUM_W-1:0] prod;
  logic [NUM_CH-1:0][SUM_W-1:0] rem;
  logic [TIME_W-1:0] a_now_q;
  avg_item_t item_q;

  assign b_ready    = !b_vld_q || out_ready_i;
  assign a_ready    = !a_vld_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c]  = (2*SUM_W)'(sum_i[c]) * (2*SUM_W)'(RECIP);
      est_d[c] = RAW_W'(prod[c] >> SUM_W);
      rem[c]   = a_sum_q[c] - SUM_W'(a_est_q[c]) * SUM_W'(WINDOW);
      cur_d[c] = (rem[c] >= SUM_W'(WINDOW)) ? a_est_q[c] + 1'b1 : a_est_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld_q <= in_valid_i;
      end
      if (b_ready) begin
        b_vld_q <= a_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_first_q <= first_i;
      a_sum_q   <= sum_i;
      a_est_q   <= est_d;
      a_now_q   <= now_i;
    end
    if (b_ready && a_vld_q) begin
      item_q.first <= a_first_q;
      item_q.cur   <= cur_d;
      item_q.now   <= a_now_q;
    end
  end

  assign out_valid_o = b_vld_q;
  assign item_o      = item_q;

endmodule

[src/tks_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_tracker
// Change of each filtered value against the previous transaction, largest
// mover, ratio products and display scaling products.
// ----------------------------------------------------------------------------
module tks_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tks_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tks_pkg::avg_item_t  item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tks_pkg::trk_item_t  item_o
);
  import tks_pkg::*;

  logic vld_q, in_fire;
  raw_vec_t prior_q, chg;
  raw_t max_chg;
  chan_e mover;
  trk_item_t item_q, item_d;

  assign in_ready_o = !vld_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // strictly larger wins, so ties keep the lower channel
  always_comb begin
    max_chg = '0;
    mover   = CH_NONE;
    item_d  = item_q;
    for (int c = 0; c < NUM_CH; c++) begin
      chg[c] = abs_diff(item_i.cur[c], prior_q[c]);
      if (chg[c] > max_chg) begin
        max_chg = chg[c];
        mover   = chan_e'(2'(c));
      end
      item_d.chg_scaled[c] = CHG_R_W'(chg[c]) * CHG_R_W'(cfg_i.switch_ratio);
      item_d.prod[c]       = scale_prod(chan_e'(2'(c)), item_i.cur[c], cfg_i.full_scale);
    end
    item_d.first     = item_i.first;
    item_d.cur       = item_i.cur;
    item_d.now       = item_i.now;
    item_d.max_chg   = max_chg;
    item_d.mover     = mover;
    item_d.mover_vld = (max_chg != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      prior_q <= '0;
    end else begin
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
      if (in_fire) begin
        prior_q <= item_i.cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = vld_q;
  assign item_o      = item_q;

endmodule

[src/tks_display.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tks_display
// Channel selection, display update decision, displayed-value state and the
// result register.
// ----------------------------------------------------------------------------
module tks_display (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tks_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tks_pkg::trk_item_t             item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tks_pkg::chan_e                 channel_o,
  output logic [tks_pkg::VAL_W-1:0]      value_o
);
  import tks_pkg::*;

  chan_e sel_q, sel_new, sel_eff, fwd_ch_q, out_ch_q;
  raw_vec_t disp_q;
  logic [NUM_CH-1:0] dvalid_q;
  logic [NUM_CH-1:0][PROD_W-1:0] dsp_prod_q;
  logic [TIME_W-1:0] last_q, elapsed;
  logic fwd_vld_q, out_vld_q;
  logic [VAL_W-1:0] fwd_val_q, out_val_q, val, dsp_val, step;
  logic [CHG_R_W-1:0] chg_sel;
  logic fire, do_switch, moved, late, emit, upd_disp;

  assign in_ready_o = !out_vld_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    case (sel_q)
      CH_DELAY:    chg_sel = item_i.chg_scaled[0];
      CH_FEEDBACK: chg_sel = item_i.chg_scaled[1];
      CH_LEVEL:    chg_sel = item_i.chg_scaled[2];
      default:     chg_sel = '0;
    endcase
  end

  always_comb begin
    do_switch = item_i.mover_vld && (item_i.max_chg >= cfg_i.min_change) &&
                ((sel_q == CH_NONE) ||
                 ((item_i.mover != sel_q) && (CHG_R_W'(item_i.max_chg) >= chg_sel)));
    if (item_i.first) begin
      sel_new = CH_DELAY;
    end else if (do_switch) begin
      sel_new = item_i.mover;
    end else begin
      sel_new = sel_q;
    end
    sel_eff = (sel_new == CH_NONE) ? CH_DELAY : sel_new;
    val     = div_4095(item_i.prod[sel_eff]);
    // the last written entry is not yet in the rescaled copy
    dsp_val = (fwd_vld_q && (fwd_ch_q == sel_eff)) ? fwd_val_q
                                                  : div_4095(dsp_prod_q[sel_eff]);
    step    = (sel_eff == CH_DELAY) ? cfg_i.ms_step : VAL_W'(cfg_i.pct_step);
    moved   = (sel_new != CH_NONE) &&
              (!dvalid_q[sel_eff] ||
               (abs_diff(RAW_W'(val), RAW_W'(dsp_val)) >= RAW_W'(step)));
    elapsed = item_i.now - last_q;
    late    = elapsed > TIME_W'(cfg_i.refresh_ms);
    emit    = item_i.first || moved ||
              (item_i.mover_vld && (item_i.mover != sel_new)) || late;
    upd_disp = fire && emit && !item_i.first;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= CH_NONE;
      disp_q    <= '0;
      dvalid_q  <= '0;
      last_q    <= '0;
      fwd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= upd_disp;
      if (fire) begin
        sel_q <= emit ? sel_eff : sel_new;
      end
      if (upd_disp) begin
        disp_q[sel_eff]   <= item_i.cur[sel_eff];
        dvalid_q[sel_eff] <= 1'b1;
        last_q            <= item_i.now;
      end
      if (fire && emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CH; c++) begin
      dsp_prod_q[c] <= scale_prod(chan_e'(2'(c)), disp_q[c], cfg_i.full_scale);
    end
    if (upd_disp) begin
      fwd_ch_q  <= sel_eff;
      fwd_val_q <= val;
    end
    if (fire && emit) begin
      out_ch_q  <= sel_eff;
      out_val_q <= val;
    end
  end

  assign out_valid_o = out_vld_q;
  assign channel_o   = out_ch_q;
  assign value_o     = out_val_q;

endmodule

[verif/three_knob_smoother_selector_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_knob_smoother_selector_test
// Self-checking testbench for the knob smoother and selector. A behavioral
// copy of the averaging, selection and display rules predicts every display
// transaction; directed runs cover the first reading, ties between knobs,
// time wrap and register extremes, random runs turn knobs over many register
// settings, and a long output hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module three_knob_smoother_selector_test;

  import tks_pkg::*;

  localparam int unsigned HIST_LEN        = WINDOW_DEF;
  localparam int unsigned FULL_READING    = 4095;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic [1:0]       channel;
    logic [VAL_W-1:0] value;
  } display_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [RAW_W-1:0]      raw_delay_i;
  logic [RAW_W-1:0]      raw_feedback_i;
  logic [RAW_W-1:0]      raw_level_i;
  logic [TIME_W-1:0]     now_ms_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            shown_channel_o;
  logic [VAL_W-1:0]      shown_value_o;

  // predicted block state and register copy
  raw_t              knob_hist [3][HIST_LEN];
  int unsigned       hist_slot = 0;
  bit                primed = 1'b0;
  raw_t              prev_avg [3];
  chan_e             sel_ch = CH_NONE;
  raw_t              shown_avg [3];
  bit                shown_ok [3];
  logic [TIME_W-1:0] last_refresh = '0;
  logic [11:0]       min_change_q = MIN_CHANGE_RST;
  logic [3:0]        ratio_q      = SWITCH_RATIO_RST;
  logic [15:0]       refresh_q    = REFRESH_RST;
  logic [9:0]        ms_step_q    = MS_STEP_RST;
  logic [6:0]        pct_step_q   = PCT_STEP_RST;
  logic [9:0]        full_scale_q = FULL_SCALE_RST;

  display_t          expected_displays [$];
  int unsigned       mismatches = 0;
  int unsigned       results_taken = 0;
  int unsigned       taken_seen = 0;
  int unsigned       ready_stall = 0;
  int unsigned       cycle_count = 0;
  bit                in_gaps_on = 1'b1;
  bit                out_gaps_on = 1'b1;
  logic              holding = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;
  int                knob_pos [3];
  event              hold_off_start;

  three_knob_smoother_selector i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .raw_delay_i    (raw_delay_i),
    .raw_feedback_i (raw_feedback_i),
    .raw_level_i    (raw_level_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .shown_channel_o(shown_channel_o),
    .shown_value_o  (shown_value_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned gap_between(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned scaled_reading(chan_e ch, int unsigned f);
    if (ch == CH_DELAY) return f * full_scale_q / FULL_READING;
    return f * PCT_FULL / FULL_READING;
  endfunction

  function automatic int clamp_raw(int v);
    return (v < 0) ? 0 : ((v > int'(FULL_READING)) ? int'(FULL_READING) : v);
  endfunction

  function automatic void predict_display(raw_t rd, raw_t rf, raw_t rl,
                                          logic [TIME_W-1:0] now);
    raw_t              raw [3];
    raw_t              avg [3];
    int unsigned       chg [3];
    int unsigned       sum, top, v, step;
    int                c, i, p;
    chan_e             mover;
    bit                value_moved;
    logic [TIME_W-1:0] elapsed;
    display_t          d;
    raw[0] = rd;
    raw[1] = rf;
    raw[2] = rl;
    if (!primed) begin
      for (c = 0; c < 3; c++) begin
        for (i = 0; i < HIST_LEN; i++) knob_hist[c][i] = raw[c];
        prev_avg[c] = raw[c];
      end
      hist_slot = 0;
      primed = 1'b1;
      sel_ch = CH_DELAY;
      d.channel = CH_DELAY;
      d.value = VAL_W'(scaled_reading(CH_DELAY, raw[0]));
      expected_displays.push_back(d);
      return;
    end
    top = 0;
    mover = CH_NONE;
    for (c = 0; c < 3; c++) begin
      knob_hist[c][hist_slot] = raw[c];
      sum = 0;
      for (i = 0; i < HIST_LEN; i++) sum += knob_hist[c][i];
      avg[c] = raw_t'(sum / HIST_LEN);
      chg[c] = gap_between(avg[c], prev_avg[c]);
      if (chg[c] > top) begin
        top = chg[c];
        mover = chan_e'(c);
      end
    end
    hist_slot = (hist_slot + 1) % HIST_LEN;
    if (mover != CH_NONE && top >= min_change_q) begin
      if (sel_ch == CH_NONE) begin
        sel_ch = mover;
      end else if (mover != sel_ch && top >= chg[int'(sel_ch)] * ratio_q) begin
        sel_ch = mover;
      end
    end
    value_moved = 1'b0;
    if (sel_ch != CH_NONE) begin
      p = int'(sel_ch);
      v = scaled_reading(sel_ch, avg[p]);
      step = (sel_ch == CH_DELAY) ? ms_step_q : pct_step_q;
      if (!shown_ok[p] || gap_between(v, scaled_reading(sel_ch, shown_avg[p])) >= step)
        value_moved = 1'b1;
    end
    elapsed = now - last_refresh;
    for (c = 0; c < 3; c++) prev_avg[c] = avg[c];
    if (value_moved || (mover != CH_NONE && mover != sel_ch) || elapsed > refresh_q) begin
      if (sel_ch == CH_NONE) sel_ch = CH_DELAY;
      p = int'(sel_ch);
      shown_avg[p] = avg[p];
      shown_ok[p] = 1'b1;
      last_refresh = now;
      d.channel = sel_ch;
      d.value = VAL_W'(scaled_reading(sel_ch, avg[p]));
      expected_displays.push_back(d);
    end
  endfunction

  function automatic void flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_display
    display_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_taken <= results_taken + 1;
      if (expected_displays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected display transaction: channel %0d value %0d",
                   shown_channel_o, shown_value_o);
      end else begin
        want = expected_displays.pop_front();
        if (shown_channel_o !== want.channel)
          flag_mismatch("shown_channel", want.channel, shown_channel_o);
        if (shown_value_o !== want.value)
          flag_mismatch("shown_value", want.value, shown_value_o);
      end
    end
  end

  // result receiver with random stalls
  always @(negedge clk_i) begin
    if (results_taken != taken_seen) begin
      taken_seen = results_taken;
      ready_stall = out_gaps_on ? $urandom_range(0, 4) : 0;
    end
    if (holding || ready_stall != 0) begin
      out_ready_i <= 1'b0;
      if (!holding) ready_stall = ready_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // long output hold-off
  initial begin
    forever begin
      @(hold_off_start);
      @(posedge clk_i);
      holding <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      holding <= 1'b0;
    end
  end

  task automatic send_reading(raw_t rd, raw_t rf, raw_t rl, logic [TIME_W-1:0] now);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    raw_delay_i    <= rd;
    raw_feedback_i <= rf;
    raw_level_i    <= rl;
    now_ms_i       <= now;
    do @(posedge clk_i); while (!in_ready_o);
    predict_display(rd, rf, rl, now);
  endtask

  task automatic send_knobs();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) clock_ms = $urandom();
    else if (roll < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
    else clock_ms = clock_ms + $urandom_range(0, 25);
    send_reading(raw_t'(knob_pos[0]), raw_t'(knob_pos[1]), raw_t'(knob_pos[2]), clock_ms);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_displays.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_MIN_CHANGE:   min_change_q = val[11:0];
      REG_SWITCH_RATIO: ratio_q      = val[3:0];
      REG_REFRESH:      refresh_q    = val[15:0];
      REG_MS_STEP:      ms_step_q    = val[9:0];
      REG_PCT_STEP:     pct_step_q   = val[6:0];
      REG_FULL_SCALE:   full_scale_q = val[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(logic [15:0] min_chg, logic [15:0] ratio,
                                logic [15:0] refresh, logic [15:0] ms_step,
                                logic [15:0] pct_step, logic [15:0] full_scale);
    write_reg(REG_MIN_CHANGE, min_chg);
    write_reg(REG_SWITCH_RATIO, ratio);
    write_reg(REG_REFRESH, refresh);
    write_reg(REG_MS_STEP, ms_step);
    write_reg(REG_PCT_STEP, pct_step);
    write_reg(REG_FULL_SCALE, full_scale);
  endtask

  // knob turns: one knob ramps to a target, sometimes a second one follows it,
  // the rest jitter; a share of fully random readings in between
  task automatic play_turns(int count);
    int done_n, len, k, c, roll, knob, buddy, start, buddy_start, target;
    done_n = 0;
    while (done_n < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        for (c = 0; c < 3; c++) knob_pos[c] = $urandom_range(0, FULL_READING);
        send_knobs();
        done_n++;
      end else begin
        knob = $urandom_range(0, 2);
        buddy = (roll < 35) ? (knob + int'($urandom_range(1, 2))) % 3 : -1;
        start = knob_pos[knob];
        buddy_start = (buddy >= 0) ? knob_pos[buddy] : 0;
        case ($urandom_range(0, 3))
          0: target = 0;
          1: target = FULL_READING;
          default: target = $urandom_range(0, FULL_READING);
        endcase
        len = $urandom_range(3, 16);
        for (k = 1; k <= len && done_n < count; k++) begin
          for (c = 0; c < 3; c++)
            knob_pos[c] = clamp_raw(knob_pos[c] + int'($urandom_range(0, 6)) - 3);
          knob_pos[knob] = start + (target - start) * k / len;
          if (buddy >= 0)
            knob_pos[buddy] = clamp_raw(buddy_start + (target - start) * k / len);
          send_knobs();
          done_n++;
        end
      end
    end
  endtask

  task automatic test_first_reading();
    send_reading(12'd2048, 12'd2048, 12'd2048, 32'd0);
    wait_idle();
  endtask

  task automatic test_ties_and_time();
    // equal histories, so equal steps tie and the lower knob wins
    send_reading(12'd2548, 12'd2048, 12'd2548, 32'd10);
    send_reading(12'd2048, 12'd2848, 12'd2848, 32'd20);
    send_reading(12'd2048, 12'd2848, 12'd2848, 32'd30);
    send_reading(12'd4095, 12'd4095, 12'd4095, 32'd40);
    send_reading(12'd0, 12'd0, 12'd0, 32'd45);
    send_reading(12'd0, 12'd0, 12'd0, 32'd45);
    send_reading(12'd4095, 12'd0, 12'd4095, 32'd200);
    // millisecond counter wrapping around
    send_reading(12'd4095, 12'd0, 12'd4095, 32'hFFFF_FFF0);
    send_reading(12'd4095, 12'd0, 12'd4095, 32'h0000_0005);
    send_reading(12'd0, 12'd4095, 12'd0, 32'h8000_0000);
    send_reading(12'd0, 12'd4095, 12'd0, 32'h8000_0000);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    apply_settings(16'd4095, 16'd15, 16'd65535, 16'd1023, 16'd100, 16'd1023);
    send_reading(12'd4095, 12'd0, 12'd0, 32'h8000_0001);
    send_reading(12'd0, 12'd4095, 12'd0, 32'h8000_0002);
    send_reading(12'd0, 12'd0, 12'd4095, 32'h8000_0003);
    send_reading(12'd4095, 12'd4095, 12'd4095, 32'h8001_2000);
    wait_idle();
    apply_settings(16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1);
    send_reading(12'd0, 12'd0, 12'd0, 32'h8001_2000);
    send_reading(12'd0, 12'd100, 12'd0, 32'h8001_2001);
    send_reading(12'd0, 12'd100, 12'd0, 32'h8001_2001);
    send_reading(12'd4095, 12'd100, 12'd4095, 32'h8001_2002);
    wait_idle();
    // zero ratio always lets the mover take over, zero full scale shows 0 ms
    apply_settings(16'd0, 16'd0, 16'd10, 16'd5, 16'd2, 16'd0);
    send_reading(12'd4095, 12'd0, 12'd0, 32'h8001_2003);
    send_reading(12'd4095, 12'd1000, 12'd0, 32'h8001_2004);
    send_reading(12'd0, 12'd1000, 12'd2000, 32'h8001_2005);
    send_reading(12'd4095, 12'd1000, 12'd2000, 32'h8001_2100);
    wait_idle();
    clock_ms = 32'h8001_2100;
    knob_pos[0] = 4095;
    knob_pos[1] = 1000;
    knob_pos[2] = 2000;
  endtask

  task automatic test_random_turns();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      apply_settings(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 12),
                     $urandom_range(1, 15),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 120),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, 12),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                 : $urandom_range(0, 6),
                     $urandom_range(1, 1023));
      in_gaps_on  = (phase != 2);
      out_gaps_on = (phase != 3);
      play_turns(65);
      wait_idle();
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  task automatic test_input_stall();
    apply_settings(16'd1, 16'd2, 16'd20, 16'd1, 16'd1, 16'd500);
    in_gaps_on = 1'b0;
    -> hold_off_start;
    play_turns(40);
    wait_idle();
    in_gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_MIN_CHANGE;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    raw_delay_i    = '0;
    raw_feedback_i = '0;
    raw_level_i    = '0;
    now_ms_i       = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_first_reading();
    test_ties_and_time();
    test_register_extremes();
    test_random_turns();
    test_input_stall();
    wait_idle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
